/* src/cfws_pkg.sv */
// shared types and constants for the circular fifo with search
package cfws_pkg;

    localparam int ACT_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;
    localparam int AW       = 8;
    localparam int POS_LSB  = DATA_W;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT      = 3'd0,
        ACT_GET      = 3'd1,
        ACT_PEEK     = 3'd2,
        ACT_PEEK_AT  = 3'd3,
        ACT_CONTAINS = 3'd4,
        ACT_FLUSH    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } state_t;

endpackage

/* src/circular_fifo_with_search.sv */
// ring-buffer fifo of handles with put, get, peek, indexed peek, search and flush
// sequence: put, flush and unknown actions go straight from idle to the result;
//   a get, peek or indexed peek that finds an entry adds one registered memory read;
//   contains reads and compares entries one by one, up to the fill count
// throughput: one request at a time, next beat taken the cycle after the result loads
// reset: pointers and fill count cleared, capacity set to 64, storage left unwritten
module circular_fifo_with_search #(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cfws_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cfws_pkg::IN_W-1:0]       s_tdata,   // item_value[31:0], position[37:32]
    input  logic [cfws_pkg::ACT_W-1:0]      s_tuser,   // action[2:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cfws_pkg::OUT_W-1:0]      m_tdata    // ok[0], item_out[32:1], count[39:33]
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (ITEM_WIDTH < cfws_pkg::DATA_W) ? ITEM_WIDTH : cfws_pkg::DATA_W;
    localparam int CAP_MAX_I = (DEPTH > 127) ? 127 : DEPTH;
    localparam logic [cfws_pkg::AW-1:0] CAP_MAX = cfws_pkg::AW'(CAP_MAX_I);
    localparam logic [cfws_pkg::AW-1:0] ONE     = cfws_pkg::AW'(1);

    cfws_pkg::state_t state_reg, state_next;

    logic [cfws_pkg::CNT_W-1:0] cap_reg;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [IDX_W-1:0]           tail_reg, tail_next;
    logic [cfws_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic                       scan_reg, scan_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    logic [IDX_W-1:0]           addr_reg, addr_next;
    logic [SW-1:0]              key_reg, key_next;
    logic [cfws_pkg::CNT_W-1:0] left_reg, left_next;
    logic                       res_ok_reg, res_ok_next;
    logic [SW-1:0]              res_item_reg, res_item_next;
    logic [cfws_pkg::CNT_W-1:0] res_count_reg, res_count_next;
    logic [cfws_pkg::OUT_W-1:0] out_data_reg;
    logic [SW-1:0]              rd_data_reg;

    logic [SW-1:0]              mem [DEPTH];
    logic                       mem_we;
    logic                       out_load;

    logic [cfws_pkg::AW-1:0]    cap_ext, cap_eff;
    logic [cfws_pkg::AW-1:0]    op_a, op_b, sum, wrap;
    logic                       op_step;
    logic [cfws_pkg::AW-1:0]    fill_ext, pos_ext;
    logic [SW-1:0]              in_item;
    cfws_pkg::action_t          in_act;

    assign cap_ext  = cfws_pkg::AW'(cap_reg);
    assign cap_eff  = (cap_ext == '0) ? ONE : ((cap_ext > CAP_MAX) ? CAP_MAX : cap_ext);
    assign fill_ext = cfws_pkg::AW'(fill_reg);
    assign pos_ext  = cfws_pkg::AW'(s_tdata[cfws_pkg::POS_LSB +: cfws_pkg::POS_W]);
    assign in_item  = s_tdata[SW-1:0];
    assign in_act   = cfws_pkg::action_t'(s_tuser);

    // shared index unit: add and wrap at the effective capacity
    assign sum  = op_a + op_b;
    assign wrap = (sum >= cap_eff) ? (op_step ? '0 : (sum - cap_eff)) : sum;

    assign s_tready = (state_reg == cfws_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        addr_next      = addr_reg;
        key_next       = key_reg;
        left_next      = left_reg;
        res_ok_next    = res_ok_reg;
        res_item_next  = res_item_reg;
        res_count_next = res_count_reg;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        op_a           = cfws_pkg::AW'(tail_reg);
        op_b           = ONE;
        op_step        = 1'b1;

        unique case (state_reg)
            cfws_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next      = in_item;
                    res_ok_next   = 1'b0;
                    res_item_next = '0;
                    scan_next     = 1'b0;
                    state_next    = cfws_pkg::ST_EMIT;
                    unique case (in_act)
                        cfws_pkg::ACT_PUT:
                        begin
                            if (fill_ext < cap_eff)
                            begin
                                mem_we      = 1'b1;
                                tail_next   = IDX_W'(wrap);
                                fill_next   = fill_reg + 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        cfws_pkg::ACT_GET:
                        begin
                            op_a = cfws_pkg::AW'(head_reg);
                            if (fill_reg != '0)
                            begin
                                addr_next   = head_reg;
                                head_next   = IDX_W'(wrap);
                                fill_next   = fill_reg - 1'b1;
                                res_ok_next = 1'b1;
                                state_next  = cfws_pkg::ST_READ;
                            end
                        end
                        cfws_pkg::ACT_PEEK:
                        begin
                            if (fill_reg != '0)
                            begin
                                addr_next   = head_reg;
                                res_ok_next = 1'b1;
                                state_next  = cfws_pkg::ST_READ;
                            end
                        end
                        cfws_pkg::ACT_PEEK_AT:
                        begin
                            op_a    = cfws_pkg::AW'(head_reg);
                            op_b    = pos_ext;
                            op_step = 1'b0;
                            if (pos_ext < fill_ext)
                            begin
                                addr_next   = IDX_W'(wrap);
                                res_ok_next = 1'b1;
                                state_next  = cfws_pkg::ST_READ;
                            end
                        end
                        cfws_pkg::ACT_CONTAINS:
                        begin
                            if (fill_reg != '0)
                            begin
                                addr_next  = head_reg;
                                left_next  = fill_reg;
                                scan_next  = 1'b1;
                                state_next = cfws_pkg::ST_READ;
                            end
                        end
                        cfws_pkg::ACT_FLUSH:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            fill_next   = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                    res_count_next = fill_next;
                end
            end
            cfws_pkg::ST_READ:
            begin
                state_next = cfws_pkg::ST_CHECK;
            end
            cfws_pkg::ST_CHECK:
            begin
                op_a = cfws_pkg::AW'(addr_reg);
                priority if (!scan_reg)
                begin
                    res_item_next = rd_data_reg;
                    state_next    = cfws_pkg::ST_EMIT;
                end
                else if (rd_data_reg == key_reg)
                begin
                    res_ok_next = 1'b1;
                    state_next  = cfws_pkg::ST_EMIT;
                end
                else if (left_reg == cfws_pkg::CNT_W'(1))
                begin
                    state_next = cfws_pkg::ST_EMIT;
                end
                else
                begin
                    addr_next  = IDX_W'(wrap);
                    left_next  = left_reg - 1'b1;
                    state_next = cfws_pkg::ST_READ;
                end
            end
            cfws_pkg::ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = cfws_pkg::ST_IDLE;
                end
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cfws_pkg::ST_IDLE;
            cap_reg      <= cfws_pkg::CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            scan_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            scan_reg     <= scan_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        key_reg       <= key_next;
        left_reg      <= left_next;
        res_ok_reg    <= res_ok_next;
        res_item_reg  <= res_item_next;
        res_count_reg <= res_count_next;
        if (out_load)
        begin
            out_data_reg <= {res_count_reg, cfws_pkg::DATA_W'(res_item_reg), res_ok_reg};
        end
    end

    // handle storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= in_item;
        end
        rd_data_reg <= mem[addr_reg];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cfws_pkg::AW'(fill_reg) <= CAP_MAX)
        else $error("fill count above storage depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cfws_pkg::AW'(head_reg) < CAP_MAX) && (cfws_pkg::AW'(tail_reg) < CAP_MAX))
        else $error("pointer outside storage");

    a_read_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cfws_pkg::ST_READ |=> state_reg == cfws_pkg::ST_CHECK)
        else $error("memory read not followed by check");

    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == cfws_pkg::ACT_FLUSH) |=> fill_reg == '0)
        else $error("flush left entries");

endmodule
